[rtl/fcstm_pkg.sv]
package fcstm_pkg;

	// Channel and window geometry.
	localparam int CHANNELS    = 4;
	localparam int WINDOW_LEN  = 5;
	localparam int SAMPLE_BITS = 24;

	localparam int SLOT_BITS = $clog2(WINDOW_LEN);
	localparam int CHAN_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ROW_BITS  = CHANNELS * SAMPLE_BITS;

	// Trimmed mean: the window sum less minimum and maximum, over KEEP_N entries.
	localparam int KEEP_N      = WINDOW_LEN - 2;
	localparam int ACC_BITS    = SAMPLE_BITS + $clog2(WINDOW_LEN);
	localparam int MID_BITS    = SAMPLE_BITS + $clog2(KEEP_N);
	localparam int RECIP_SHIFT = MID_BITS + $clog2(KEEP_N);
	localparam int RECIP_BITS  = RECIP_SHIFT - $clog2(KEEP_N) + 1;
	localparam logic [RECIP_BITS-1:0] RECIP =
		RECIP_BITS'(((64'd1 << RECIP_SHIFT) + KEEP_N - 1) / KEEP_N);

	// Result field widths.
	localparam int OP_BITS     = 2;
	localparam int STAT_BITS   = 2;
	localparam int EV_BITS     = 2;
	localparam int TOTAL_BITS  = SAMPLE_BITS + $clog2(CHANNELS);
	localparam int DIFF_BITS   = TOTAL_BITS + 1;
	localparam int FACTOR_BITS = 36;
	localparam int CAL_BITS    = 16;
	localparam int WEIGHT_BITS = 32;

	// Fixed-point scaling: Q8 factor, weight in tenths of grams.
	localparam int CAL_SHIFT  = 8;
	localparam int SCALE_BITS = 12;
	localparam logic [SCALE_BITS-1:0] WEIGHT_SCALE = 12'd2560;

	// Shared divider geometry.
	localparam int DVD_BITS     = DIFF_BITS + SCALE_BITS;
	localparam int DVS_BITS     = FACTOR_BITS;
	localparam int DIV_CNT_BITS = $clog2(DVD_BITS + 1);

	// Reset values.
	localparam logic signed [FACTOR_BITS-1:0] FACTOR_RESET = 36'sd2048000;
	localparam logic [CAL_BITS-1:0]           CAL_RESET    = 16'd1000;

	// Command, status and event codes.
	localparam logic [OP_BITS-1:0]   OP_TARE       = 2'd1;
	localparam logic [OP_BITS-1:0]   OP_CAL        = 2'd2;
	localparam logic [STAT_BITS-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_BITS-1:0] STAT_OFFLINE  = 2'd1;
	localparam logic [STAT_BITS-1:0] STAT_REJECT   = 2'd2;
	localparam logic [EV_BITS-1:0]   EV_NONE       = 2'd0;
	localparam logic [EV_BITS-1:0]   EV_TARE       = 2'd1;
	localparam logic [EV_BITS-1:0]   EV_CAL        = 2'd2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [ROW_BITS-1:0]           row_t;

	typedef struct packed {
		logic                 en;
		logic [SLOT_BITS-1:0] addr;
		row_t                 data;
	} mem_wr_t;

	typedef struct packed {
		logic clear;
		logic row_valid;
		logic mean_start;
	} trim_ctl_t;

	typedef struct packed {
		logic                start;
		logic [DVD_BITS-1:0] dividend;
		logic [DVS_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [DVD_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

[rtl/fcstm_if.sv]
// Input item channel: one sample set with command and read-ok flag.
interface fcstm_item_if import fcstm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OP_BITS-1:0]   op;
	logic                 read_ok;
	sample_t              sample_ch0;
	sample_t              sample_ch1;
	sample_t              sample_ch2;
	sample_t              sample_ch3;

	modport source (output valid, op, read_ok, sample_ch0, sample_ch1, sample_ch2,
		sample_ch3, input ready);
	modport sink (input valid, op, read_ok, sample_ch0, sample_ch1, sample_ch2,
		sample_ch3, output ready);
endinterface

// Result item channel.
interface fcstm_result_if import fcstm_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [STAT_BITS-1:0]          status;
	logic [EV_BITS-1:0]            event_res;
	sample_t                       mean_ch0;
	sample_t                       mean_ch1;
	sample_t                       mean_ch2;
	sample_t                       mean_ch3;
	logic signed [TOTAL_BITS-1:0]  zero_point;
	logic signed [FACTOR_BITS-1:0] counts_per_gram_q8;
	logic signed [WEIGHT_BITS-1:0] weight_decigrams;

	modport source (output valid, status, event_res, mean_ch0, mean_ch1, mean_ch2,
		mean_ch3, zero_point, counts_per_gram_q8, weight_decigrams, input ready);
	modport sink (input valid, status, event_res, mean_ch0, mean_ch1, mean_ch2,
		mean_ch3, zero_point, counts_per_gram_q8, weight_decigrams, output ready);
endinterface

// Configuration write channel for the calibration weight.
interface fcstm_cfg_if import fcstm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CAL_BITS-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[rtl/fcstm_ring_mem.sv]
module fcstm_ring_mem import fcstm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mem_wr_t              wr,
	input  logic                 rd_en,
	input  logic [SLOT_BITS-1:0] rd_addr,
	output row_t                 rd_data
);

	// One row per window slot, all channels side by side.
	row_t                  mem_q [WINDOW_LEN];
	row_t                  rd_data_q;
	logic [WINDOW_LEN-1:0] row_valid_q;
	logic                  rd_hit_q;

	// Storage array with a registered read port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Rows never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_hit_q    <= 1'b0;
		end else begin
			if (wr.en) begin
				row_valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= row_valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_data_q : '0;

endmodule

[rtl/fcstm_trim.sv]
module fcstm_trim import fcstm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  trim_ctl_t ctl,
	input  row_t      row,
	output sample_t   means [CHANNELS],
	output logic      done
);

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	sample_t                     lane [CHANNELS];
	logic signed [ACC_BITS-1:0]  sum_q [CHANNELS];
	sample_t                     min_q [CHANNELS];
	sample_t                     max_q [CHANNELS];
	sample_t                     means_q [CHANNELS];

	logic                        run_q;
	logic [CHAN_BITS-1:0]        chan_q;
	logic signed [ACC_BITS-1:0]  mid_full;
	logic signed [MID_BITS-1:0]  mid;
	logic [MID_BITS-1:0]         mag;

	logic                        v_s1;
	logic [CHAN_BITS-1:0]        ch_s1;
	logic                        neg_s1;
	logic [MID_BITS-1:0]         mag_s1;
	logic                        v_s2;
	logic [CHAN_BITS-1:0]        ch_s2;
	logic                        neg_s2;
	logic [MID_BITS+RECIP_BITS-1:0] prod_s2;
	logic [SAMPLE_BITS-1:0]      quo;
	logic                        done_q;

	// Split the row into its channel lanes.
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			lane[c] = sample_t'(row[c*SAMPLE_BITS +: SAMPLE_BITS]);
		end
	end

	// Running sum, minimum and maximum per lane as the rows stream in.
	always_ff @(posedge clk) begin
		for (int c = 0; c < CHANNELS; c++) begin
			if (ctl.clear) begin
				sum_q[c] <= '0;
				min_q[c] <= SAMPLE_MAX;
				max_q[c] <= SAMPLE_MIN;
			end else if (ctl.row_valid) begin
				sum_q[c] <= sum_q[c] + ACC_BITS'(lane[c]);
				if (lane[c] < min_q[c]) begin
					min_q[c] <= lane[c];
				end
				if (lane[c] > max_q[c]) begin
					max_q[c] <= lane[c];
				end
			end
		end
	end

	// Middle sum of the selected channel and its magnitude.
	always_comb begin
		mid_full = sum_q[chan_q] - ACC_BITS'(min_q[chan_q]) - ACC_BITS'(max_q[chan_q]);
		mid      = mid_full[MID_BITS-1:0];
		mag      = mid[MID_BITS-1] ? MID_BITS'(-mid) : MID_BITS'(mid);
	end

	assign quo = prod_s2[RECIP_SHIFT +: SAMPLE_BITS];

	// Channel sequencer and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			chan_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= run_q;
			v_s2   <= v_s1;
			done_q <= v_s2 && (ch_s2 == CHAN_BITS'(CHANNELS - 1));
			if (ctl.mean_start) begin
				run_q  <= 1'b1;
				chan_q <= '0;
			end else if (run_q) begin
				chan_q <= chan_q + 1'b1;
				if (chan_q == CHAN_BITS'(CHANNELS - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Division by the kept count: reciprocal multiply, then shift and sign.
	always_ff @(posedge clk) begin
		if (run_q) begin
			ch_s1  <= chan_q;
			neg_s1 <= mid[MID_BITS-1];
			mag_s1 <= mag;
		end
		if (v_s1) begin
			ch_s2   <= ch_s1;
			neg_s2  <= neg_s1;
			prod_s2 <= mag_s1 * RECIP;
		end
		if (v_s2) begin
			means_q[ch_s2] <= neg_s2 ? sample_t'(-quo) : sample_t'(quo);
		end
	end

	assign means = means_q;
	assign done  = done_q;

endmodule

[rtl/fcstm_divider.sv]
module fcstm_divider import fcstm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DVS_BITS-1:0]     rem_q;
	logic [DVD_BITS-1:0]     quo_q;
	logic [DVS_BITS-1:0]     dvs_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DVS_BITS:0]       trial;
	logic [DVS_BITS:0]       trial_sub;
	logic                    fits;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial     = {rem_q, quo_q[DVD_BITS-1]};
		trial_sub = trial - {1'b0, dvs_q};
		fits      = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_BITS'(DVD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient register starts as the dividend and fills with quotient bits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
			quo_q <= {quo_q[DVD_BITS-2:0], fits};
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, quotient: quo_q};

endmodule

[rtl/four_channel_scale_trimmed_mean_unit.sv]
// Four-channel load-cell scale. Each accepted item with read_ok set is written as one row of a
// five-slot sample ring memory; the ring is then read back one row per cycle, each channel's
// window is trimmed of its minimum and maximum and averaged, and the net weight is divided out
// by a shared radix-2 divider that settles one quotient bit per cycle. The 39-bit weight division
// ends the work on a good item; a calibrate command runs a second division first. An offline
// item skips the ring and the divider and goes straight to the emit state. One item is in
// work at a time, and the next item is accepted while the previous result still waits in the
// output register. The ring rows carry valid bits cleared by reset, so there is no clearing
// pass. The calibration weight register is written at any time through the configuration
// channel and is used by the next calibrate.
module four_channel_scale_trimmed_mean_unit import fcstm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	fcstm_cfg_if.sink     cfg,
	fcstm_item_if.sink    item,
	fcstm_result_if.source result
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_READ   = 4'd1;
	localparam logic [3:0] S_LAST   = 4'd2;
	localparam logic [3:0] S_MEAN   = 4'd3;
	localparam logic [3:0] S_TOTAL  = 4'd4;
	localparam logic [3:0] S_TARE   = 4'd5;
	localparam logic [3:0] S_CSTART = 4'd6;
	localparam logic [3:0] S_CAL    = 4'd7;
	localparam logic [3:0] S_WSTART = 4'd8;
	localparam logic [3:0] S_WDIV   = 4'd9;
	localparam logic [3:0] S_EMIT   = 4'd10;

	localparam logic [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
	localparam logic [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

	logic [3:0]                    state_q;
	logic [CAL_BITS-1:0]           cal_weight_q;
	logic [SLOT_BITS-1:0]          write_slot_q;
	logic [SLOT_BITS-1:0]          rd_cnt_q;
	logic                          rd_v_s1;
	logic                          first_seen_q;
	logic signed [TOTAL_BITS-1:0]  tare_q;
	logic signed [FACTOR_BITS-1:0] factor_q;
	logic                          res_valid_q;

	logic [OP_BITS-1:0]            op_q;
	logic                          offline_q;
	logic [STAT_BITS-1:0]          status_q;
	logic [EV_BITS-1:0]            event_q;
	logic signed [TOTAL_BITS-1:0]  total_q;
	logic signed [DIFF_BITS-1:0]   diff_q;
	logic [WEIGHT_BITS-1:0]        weight_q;

	logic [STAT_BITS-1:0]          res_status_q;
	logic [EV_BITS-1:0]            res_event_q;
	sample_t                       res_means_q [CHANNELS];
	logic signed [TOTAL_BITS-1:0]  res_zero_q;
	logic signed [FACTOR_BITS-1:0] res_factor_q;
	logic [WEIGHT_BITS-1:0]        res_weight_q;

	logic                          accept;
	logic                          emit_go;
	logic                          cal_go;
	sample_t                       in_smp [CHANNELS];
	sample_t                       means [CHANNELS];
	logic                          trim_done;
	logic signed [TOTAL_BITS-1:0]  raw_sum;
	logic signed [TOTAL_BITS-1:0]  mean_sum;
	logic [DIFF_BITS-1:0]          diff_mag;
	logic [FACTOR_BITS-1:0]        factor_mag;
	logic [DVD_BITS-1:0]           diff_mag_ext;
	logic [FACTOR_BITS-1:0]        cal_mag;
	logic signed [FACTOR_BITS-1:0] cal_factor;
	logic                          cal_zero;
	logic                          w_neg;
	logic [WEIGHT_BITS-1:0]        weight_sat;

	mem_wr_t                       mem_wr;
	row_t                          rd_data;
	trim_ctl_t                     trim_ctl;
	div_req_t                      div_req;
	div_rsp_t                      div_rsp;

	assign accept     = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign emit_go    = !res_valid_q || result.ready;
	assign cal_go     = (op_q == OP_CAL) && (cal_weight_q != '0);

	// Incoming samples and their raw sum for the first tare.
	always_comb begin
		in_smp[0] = item.sample_ch0;
		in_smp[1] = item.sample_ch1;
		in_smp[2] = item.sample_ch2;
		in_smp[3] = item.sample_ch3;
		raw_sum   = '0;
		mean_sum  = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			raw_sum  = raw_sum + TOTAL_BITS'(in_smp[c]);
			mean_sum = mean_sum + TOTAL_BITS'(means[c]);
		end
	end

	// Ring write at acceptance, then a read sweep over all slots.
	always_comb begin
		mem_wr.en   = accept && item.read_ok;
		mem_wr.addr = write_slot_q;
		for (int c = 0; c < CHANNELS; c++) begin
			mem_wr.data[c*SAMPLE_BITS +: SAMPLE_BITS] = in_smp[c];
		end
	end

	fcstm_ring_mem u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mem_wr),
		.rd_en   (state_q == S_READ),
		.rd_addr (rd_cnt_q),
		.rd_data (rd_data)
	);

	assign trim_ctl = '{clear: accept, row_valid: rd_v_s1, mean_start: (state_q == S_LAST)};

	fcstm_trim u_trim (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (trim_ctl),
		.row    (rd_data),
		.means  (means),
		.done   (trim_done)
	);

	// Divider operands: calibration first when asked, then the weight.
	always_comb begin
		diff_mag     = diff_q[DIFF_BITS-1] ? DIFF_BITS'(-diff_q) : DIFF_BITS'(diff_q);
		factor_mag   = factor_q[FACTOR_BITS-1] ? FACTOR_BITS'(-factor_q) : FACTOR_BITS'(factor_q);
		diff_mag_ext = DVD_BITS'(diff_mag);
		div_req.start    = ((state_q == S_CSTART) && cal_go) || (state_q == S_WSTART);
		if (state_q == S_CSTART) begin
			div_req.dividend = DVD_BITS'({diff_mag, {CAL_SHIFT{1'b0}}});
			div_req.divisor  = DVS_BITS'(cal_weight_q);
		end else begin
			div_req.dividend = diff_mag_ext * WEIGHT_SCALE;
			div_req.divisor  = factor_mag;
		end
	end

	fcstm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Signed calibration factor and saturated weight from the quotient.
	always_comb begin
		cal_mag    = div_rsp.quotient[FACTOR_BITS-1:0];
		cal_zero   = (div_rsp.quotient == '0);
		cal_factor = diff_q[DIFF_BITS-1] ? FACTOR_BITS'(-cal_mag) : FACTOR_BITS'(cal_mag);
		w_neg      = diff_q[DIFF_BITS-1] ^ factor_q[FACTOR_BITS-1];
		if (!w_neg) begin
			weight_sat = (div_rsp.quotient > DVD_BITS'(W_MAX)) ? W_MAX
				: div_rsp.quotient[WEIGHT_BITS-1:0];
		end else begin
			weight_sat = (div_rsp.quotient > DVD_BITS'(W_MIN)) ? W_MIN
				: -div_rsp.quotient[WEIGHT_BITS-1:0];
		end
	end

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cal_weight_q <= CAL_RESET;
			write_slot_q <= '0;
			rd_cnt_q     <= '0;
			rd_v_s1      <= 1'b0;
			first_seen_q <= 1'b0;
			tare_q       <= '0;
			factor_q     <= FACTOR_RESET;
			res_valid_q  <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_READ);
			if (cfg.valid) begin
				cal_weight_q <= cfg.data;
			end
			// The output register fills on emit and empties when the result is taken.
			if ((state_q == S_EMIT) && emit_go) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.read_ok) begin
							if (!first_seen_q) begin
								first_seen_q <= 1'b1;
								tare_q       <= raw_sum;
							end
							write_slot_q <= (write_slot_q == SLOT_BITS'(WINDOW_LEN - 1)) ? '0
								: write_slot_q + 1'b1;
							rd_cnt_q <= '0;
							state_q  <= S_READ;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == SLOT_BITS'(WINDOW_LEN - 1)) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_MEAN;
				end
				S_MEAN: begin
					if (trim_done) begin
						state_q <= S_TOTAL;
					end
				end
				S_TOTAL: begin
					state_q <= S_TARE;
				end
				S_TARE: begin
					if (op_q == OP_TARE) begin
						tare_q <= total_q;
					end
					state_q <= S_CSTART;
				end
				S_CSTART: begin
					state_q <= cal_go ? S_CAL : S_WSTART;
				end
				S_CAL: begin
					if (div_rsp.done) begin
						if (!cal_zero) begin
							factor_q <= cal_factor;
						end
						state_q <= S_WSTART;
					end
				end
				S_WSTART: begin
					state_q <= S_WDIV;
				end
				S_WDIV: begin
					if (div_rsp.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-item working values and the output register.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= item.op;
					offline_q <= !item.read_ok;
					status_q  <= item.read_ok ? STAT_OK : STAT_OFFLINE;
					event_q   <= EV_NONE;
					weight_q  <= '0;
				end
			end
			S_TOTAL: begin
				total_q <= mean_sum;
			end
			S_TARE: begin
				if (op_q == OP_TARE) begin
					diff_q  <= '0;
					event_q <= EV_TARE;
				end else begin
					diff_q <= DIFF_BITS'(total_q) - DIFF_BITS'(tare_q);
				end
			end
			S_CSTART: begin
				if ((op_q == OP_CAL) && !cal_go) begin
					status_q <= STAT_REJECT;
				end
			end
			S_CAL: begin
				if (div_rsp.done) begin
					if (cal_zero) begin
						status_q <= STAT_REJECT;
					end else begin
						event_q <= EV_CAL;
					end
				end
			end
			S_WDIV: begin
				if (div_rsp.done) begin
					weight_q <= weight_sat;
				end
			end
			S_EMIT: begin
				if (emit_go) begin
					res_status_q <= status_q;
					res_event_q  <= event_q;
					for (int c = 0; c < CHANNELS; c++) begin
						res_means_q[c] <= offline_q ? sample_t'(0) : means[c];
					end
					res_zero_q   <= tare_q;
					res_factor_q <= factor_q;
					res_weight_q <= weight_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid              = res_valid_q;
	assign result.status             = res_status_q;
	assign result.event_res          = res_event_q;
	assign result.mean_ch0           = res_means_q[0];
	assign result.mean_ch1           = res_means_q[1];
	assign result.mean_ch2           = res_means_q[2];
	assign result.mean_ch3           = res_means_q[3];
	assign result.zero_point         = res_zero_q;
	assign result.counts_per_gram_q8 = res_factor_q;
	assign result.weight_decigrams   = res_weight_q;

`ifndef NO_ASSERTIONS
	// The divider is quiet whenever a new item can be taken.
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !div_rsp.busy)
		else $error("divider busy while accepting an item");

	// A division only completes in a state that waits for it.
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_CAL || state_q == S_WDIV))
		else $error("divider result arrived in an unexpected state");

	// An offline result reports no event and no weight.
	a_offline: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == STAT_OFFLINE)
		|-> (result.event_res == EV_NONE && result.weight_decigrams == '0))
		else $error("offline result carries an event or a weight");
`endif

endmodule

[tb/sv/four_channel_scale_trimmed_mean_unit_tb.sv]
`timescale 1ns / 100ps

module four_channel_scale_trimmed_mean_unit_tb;
	import fcstm_pkg::*;

	// Command codes that the package leaves unnamed.
	localparam logic [OP_BITS-1:0] OP_IDLE  = 2'd0;
	localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 150;
	localparam int PHASES       = 11;
	localparam int PHASE_ITEMS  = 103;

	localparam longint CAL_ONE    = longint'(1) << CAL_SHIFT;
	localparam longint WEIGHT_MUL = longint'(WEIGHT_SCALE);

	typedef sample_t [CHANNELS-1:0] sample_set_t;

	// One scale reading as the result channel carries it.
	typedef struct packed {
		logic [STAT_BITS-1:0]          status;
		logic [EV_BITS-1:0]            ev;
		sample_set_t                   mean;
		logic signed [TOTAL_BITS-1:0]  zero_point;
		logic signed [FACTOR_BITS-1:0] factor;
		logic signed [WEIGHT_BITS-1:0] weight;
	} reading_t;

	// One directed item, with a hand-written reading where it is obvious.
	typedef struct packed {
		logic [OP_BITS-1:0] op;
		logic               ok;
		sample_set_t        set;
		bit                 pinned;
		reading_t           want;
	} script_row_t;

	localparam sample_t SMAX = 24'h7FFFFF;
	localparam sample_t SMIN = 24'h800000;
	localparam sample_set_t ALL_MAX = {SMAX, SMAX, SMAX, SMAX};
	localparam sample_set_t ALL_MIN = {SMIN, SMIN, SMIN, SMIN};
	localparam sample_set_t JUNK    = {24'h5A5A5A, 24'hA5A5A5, 24'h123456, 24'hFEDCBA};
	localparam sample_set_t MIXED   = {24'hFFFFFF, 24'h000000, SMIN, SMAX};

	// An offline item before any good set only shows the reset state.
	localparam reading_t RESET_OFFLINE = '{STAT_OFFLINE, EV_NONE, '0, '0, FACTOR_RESET, '0};

	localparam int SCRIPT_LEN = 21;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{OP_IDLE,  1'b0, '0,      1'b1, RESET_OFFLINE},
		'{OP_TARE,  1'b0, JUNK,    1'b1, RESET_OFFLINE},
		'{OP_CAL,   1'b0, ALL_MAX, 1'b1, RESET_OFFLINE},
		'{OP_SPARE, 1'b0, ALL_MIN, 1'b1, RESET_OFFLINE},
		'{OP_TARE,  1'b1, ALL_MAX, 1'b0, '0},
		'{OP_IDLE,  1'b1, ALL_MAX, 1'b0, '0},
		'{OP_IDLE,  1'b1, ALL_MAX, 1'b0, '0},
		'{OP_IDLE,  1'b1, ALL_MAX, 1'b0, '0},
		'{OP_IDLE,  1'b1, ALL_MAX, 1'b0, '0},
		'{OP_IDLE,  1'b1, ALL_MIN, 1'b0, '0},
		'{OP_IDLE,  1'b1, ALL_MIN, 1'b0, '0},
		'{OP_IDLE,  1'b1, ALL_MIN, 1'b0, '0},
		'{OP_IDLE,  1'b1, ALL_MIN, 1'b0, '0},
		'{OP_CAL,   1'b1, ALL_MIN, 1'b0, '0},
		'{OP_TARE,  1'b1, ALL_MIN, 1'b0, '0},
		'{OP_CAL,   1'b1, ALL_MIN, 1'b0, '0},
		'{OP_SPARE, 1'b1, MIXED,   1'b0, '0},
		'{OP_TARE,  1'b0, MIXED,   1'b0, '0},
		'{OP_IDLE,  1'b1, {24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA}, 1'b0, '0},
		'{OP_CAL,   1'b1, {24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555}, 1'b0, '0},
		'{OP_IDLE,  1'b1, {24'h000001, 24'hFFFFFF, 24'h000001, 24'hFFFFFF}, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	fcstm_cfg_if    cfg_ch ();
	fcstm_item_if   item_ch ();
	fcstm_result_if res_ch ();

	four_channel_scale_trimmed_mean_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (res_ch)
	);

	// Scale state as the predictor sees it.
	longint ring [CHANNELS][WINDOW_LEN] = '{default: 0};
	int     ring_slot  = 0;
	longint tare_now   = 0;
	longint factor_now = FACTOR_RESET;
	bit     seen_good  = 1'b0;
	longint cal_grams  = CAL_RESET;

	reading_t    expected_readings [$];
	reading_t    pin_want;
	bit          pin_now;
	reading_t    mon_want;
	sample_set_t mon_set;

	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int items_sent = 0;
	int cycles = 0;
	int errors = 0;
	int n_results = 0;
	int n_offline = 0;
	int n_tare = 0;
	int n_cal = 0;
	int n_reject = 0;
	int n_clip = 0;
	int cal_writes = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic longint clamp(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	// Sort one channel's window, drop both ends and average the rest toward zero.
	function automatic longint window_mean(int c);
		longint w [WINDOW_LEN];
		longint key;
		longint acc;
		int i;
		int j;
		for (i = 0; i < WINDOW_LEN; i++)
			w[i] = ring[c][i];
		for (i = 1; i < WINDOW_LEN; i++) begin
			key = w[i];
			j = i - 1;
			while (j >= 0 && w[j] > key) begin
				w[j + 1] = w[j];
				j--;
			end
			w[j + 1] = key;
		end
		acc = 0;
		for (i = 1; i < WINDOW_LEN - 1; i++)
			acc += w[i];
		return acc / KEEP_N;
	endfunction

	// Apply one accepted item to the scale state and return the reading it gives.
	function automatic reading_t predict_reading(logic [OP_BITS-1:0] op, logic ok,
			sample_set_t set);
		reading_t r;
		longint total;
		longint m;
		longint f;
		longint wt;
		int c;
		r = '0;
		wt = 0;
		if (!ok) begin
			r.status = STAT_OFFLINE;
		end else begin
			total = 0;
			for (c = 0; c < CHANNELS; c++) begin
				ring[c][ring_slot] = longint'($signed(set[c]));
				total += ring[c][ring_slot];
			end
			// The first good set after reset takes the raw sum as tare.
			if (!seen_good) begin
				seen_good = 1'b1;
				tare_now = clamp(total, TOTAL_BITS);
			end
			ring_slot = (ring_slot + 1) % WINDOW_LEN;

			total = 0;
			for (c = 0; c < CHANNELS; c++) begin
				m = window_mean(c);
				r.mean[c] = sample_t'(m);
				total += m;
			end

			if (op == OP_TARE) begin
				tare_now = clamp(total, TOTAL_BITS);
				r.ev = EV_TARE;
			end else if (op == OP_CAL) begin
				if (cal_grams == 0) begin
					r.status = STAT_REJECT;
				end else begin
					f = clamp(((total - tare_now) * CAL_ONE) / cal_grams, FACTOR_BITS);
					if (f == 0) begin
						r.status = STAT_REJECT;
					end else begin
						factor_now = f;
						r.ev = EV_CAL;
					end
				end
			end

			if (factor_now != 0)
				wt = clamp(((total - tare_now) * WEIGHT_MUL) / factor_now, WEIGHT_BITS);
		end
		r.zero_point = tare_now[TOTAL_BITS-1:0];
		r.factor = factor_now[FACTOR_BITS-1:0];
		r.weight = wt[WEIGHT_BITS-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Watch all three handshakes on the rising edge.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				n_results++;
				if (expected_readings.size() == 0) begin
					$error("result item arrived with no reading outstanding");
					errors++;
				end else begin
					mon_want = expected_readings.pop_front();
					check_field("status", mon_want.status, res_ch.status);
					check_field("event_res", mon_want.ev, res_ch.event_res);
					check_field("mean_ch0", $signed(mon_want.mean[0]), $signed(res_ch.mean_ch0));
					check_field("mean_ch1", $signed(mon_want.mean[1]), $signed(res_ch.mean_ch1));
					check_field("mean_ch2", $signed(mon_want.mean[2]), $signed(res_ch.mean_ch2));
					check_field("mean_ch3", $signed(mon_want.mean[3]), $signed(res_ch.mean_ch3));
					check_field("zero_point", mon_want.zero_point, res_ch.zero_point);
					check_field("counts_per_gram_q8", mon_want.factor,
						res_ch.counts_per_gram_q8);
					check_field("weight_decigrams", mon_want.weight, res_ch.weight_decigrams);
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				mon_set[0] = item_ch.sample_ch0;
				mon_set[1] = item_ch.sample_ch1;
				mon_set[2] = item_ch.sample_ch2;
				mon_set[3] = item_ch.sample_ch3;
				mon_want = predict_reading(item_ch.op, item_ch.read_ok, mon_set);
				if (pin_now)
					mon_want = pin_want;
				expected_readings.push_back(mon_want);
				if (mon_want.status == STAT_OFFLINE)
					n_offline++;
				if (mon_want.status == STAT_REJECT)
					n_reject++;
				if (mon_want.ev == EV_TARE)
					n_tare++;
				if (mon_want.ev == EV_CAL)
					n_cal++;
				if (mon_want.weight == {1'b0, {(WEIGHT_BITS-1){1'b1}}} ||
						mon_want.weight == {1'b1, {(WEIGHT_BITS-1){1'b0}}})
					n_clip++;
			end
			if (cfg_ch.valid && cfg_ch.ready)
				cal_grams = cfg_ch.data;
		end
	end

	// Result side: stall a random number of cycles before each item, with calm stretches.
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_steady = !rx_steady;
			stall = rx_steady ? 0 : $urandom_range(0, 14);
			repeat (stall) begin
				@(negedge clk);
				res_ch.ready = 1'b0;
			end
			@(negedge clk);
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	end

	task automatic send_item(input logic [OP_BITS-1:0] op, input logic ok,
			input sample_set_t set, input bit pinned = 1'b0, input reading_t want = '0);
		int gap;
		if ($urandom_range(0, 59) == 0)
			tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, 14);
		repeat (gap) begin
			@(negedge clk);
			item_ch.valid = 1'b0;
		end
		@(negedge clk);
		item_ch.op = op;
		item_ch.read_ok = ok;
		item_ch.sample_ch0 = set[0];
		item_ch.sample_ch1 = set[1];
		item_ch.sample_ch2 = set[2];
		item_ch.sample_ch3 = set[3];
		pin_now = pinned;
		pin_want = want;
		item_ch.valid = 1'b1;
		do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
		items_sent++;
	endtask

	// A steady load with converter noise; now and then the converters drop out.
	task automatic send_level(logic [OP_BITS-1:0] op, longint lvl [CHANNELS], longint noise);
		sample_set_t set;
		int c;
		for (c = 0; c < CHANNELS; c++)
			set[c] = sample_t'(clamp(lvl[c] + longint'($urandom_range(0, 2 * noise)) - noise,
				SAMPLE_BITS));
		send_item(op, $urandom_range(0, 15) != 0, set);
	endtask

	function automatic longint rand_step();
		int k;
		longint mag;
		k = $urandom_range(0, 23);
		mag = longint'($urandom_range(0, (1 << k) - 1));
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// Settle on an empty scale, tare, load it, calibrate, then weigh a new load.
	task automatic weigh_sequence();
		longint base [CHANNELS];
		longint lvl [CHANNELS];
		longint noise;
		int c;
		int k;
		int fill;
		int hold;
		int cal_at;
		case ($urandom_range(0, 2))
			0: noise = 0;
			1: noise = $urandom_range(1, 15);
			default: noise = $urandom_range(16, 65535);
		endcase
		for (c = 0; c < CHANNELS; c++) begin
			case ($urandom_range(0, 3))
				0: base[c] = longint'($signed(sample_t'($urandom)));
				1: base[c] = 0;
				default: base[c] = rand_step() >>> $urandom_range(0, 7);
			endcase
		end
		fill = $urandom_range(WINDOW_LEN, WINDOW_LEN + 3);
		for (k = 0; k < fill; k++)
			send_level(($urandom_range(0, 7) == 0) ? OP_SPARE : OP_IDLE, base, noise);
		send_level(OP_TARE, base, noise);

		for (c = 0; c < CHANNELS; c++)
			lvl[c] = base[c] + rand_step();
		hold = $urandom_range(WINDOW_LEN, WINDOW_LEN + 4);
		cal_at = $urandom_range(WINDOW_LEN - 1, hold - 1);
		for (k = 0; k < hold; k++)
			send_level((k == cal_at) ? OP_CAL : OP_IDLE, lvl, noise);

		for (c = 0; c < CHANNELS; c++)
			lvl[c] = base[c] + rand_step();
		fill = $urandom_range(0, 6);
		for (k = 0; k < fill; k++)
			send_level(OP_IDLE, lvl, noise);
	endtask

	// Let every outstanding reading come back before touching the register.
	task automatic wait_idle();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (expected_readings.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_cal(logic [CAL_BITS-1:0] grams);
		@(negedge clk);
		cfg_ch.data = grams;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		cal_writes++;
	endtask

	// Main stimulus: directed rows first, then phases of random weighing per register value.
	initial begin
		int i;
		int ph;
		int n;
		int target;
		logic [CAL_BITS-1:0] grams;
		sample_set_t set;

		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_IDLE;
		item_ch.read_ok = 1'b0;
		item_ch.sample_ch0 = '0;
		item_ch.sample_ch1 = '0;
		item_ch.sample_ch2 = '0;
		item_ch.sample_ch3 = '0;
		pin_now = 1'b0;
		pin_want = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < SCRIPT_LEN; i++)
			send_item(SCRIPT[i].op, SCRIPT[i].ok, SCRIPT[i].set, SCRIPT[i].pinned,
				SCRIPT[i].want);

		for (ph = 0; ph < PHASES; ph++) begin
			// Zero weight, both extremes, the reset value, and random values between.
			case (ph)
				0: grams = '0;
				1: grams = 16'd1;
				2: grams = '1;
				PHASES - 1: grams = CAL_RESET;
				default: grams = CAL_BITS'($urandom_range(1, 65535));
			endcase
			wait_idle();
			write_cal(grams);
			target = SCRIPT_LEN + (ph + 1) * PHASE_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(0, 3) != 0) begin
					weigh_sequence();
				end else begin
					n = $urandom_range(1, 8);
					repeat (n) begin
						for (i = 0; i < CHANNELS; i++)
							set[i] = sample_t'($urandom);
						send_item(OP_BITS'($urandom_range(0, OP_SPARE)),
							$urandom_range(0, 7) != 0, set);
					end
				end
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items and %0d results over %0d calibration weight settings.",
			items_sent, n_results, cal_writes);
		$display("Seen: %0d offline, %0d tares, %0d factor updates, %0d rejects, %0d clipped.",
			n_offline, n_tare, n_cal, n_reject, n_clip);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
